>>> hdl/cubic_bezier_easing_bisection_top_defines.svh
// ---------------------------------------------------------------------------
// Cubic Bezier easing: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_EASING_BISECTION_TOP_DEFINES_SVH
`define CUBIC_BEZIER_EASING_BISECTION_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBEB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBEB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/cbeb_pkg.sv
// ---------------------------------------------------------------------------
// Cubic Bezier easing: shared package
// Default sizes, pipeline constants and the types shared by the design.
// ---------------------------------------------------------------------------
`default_nettype none

package cbeb_pkg;

  // Default number of fraction bits of every fixed-point value.
  localparam int unsigned CBEB_FRAC_BITS = 16;

  // Default number of bisection steps on the curve parameter.
  localparam int unsigned CBEB_BISECT_STEPS = 16;

  // Register stages inside one curve evaluation.
  localparam int unsigned CBEB_BEZ_LATENCY = 3;

  // How a transaction is resolved once the curve has been evaluated.
  typedef enum logic [1:0] {
    KIND_SOLVE,
    KIND_ZERO,
    KIND_ONE
  } kind_t;

  // Control that travels alongside every pipeline stage.
  typedef struct packed {
    logic  valid;
    kind_t kind;
  } pipe_ctl_t;

endpackage

`default_nettype wire

>>> hdl/cbeb_chan_if.sv
// ---------------------------------------------------------------------------
// Cubic Bezier easing: channel interfaces
// Valid/ready channels for the input transactions and for the results.
// ---------------------------------------------------------------------------
`default_nettype none

// Input channel: both control points and the curve position.
interface cbeb_in_if import cbeb_pkg::*; #(
  parameter int unsigned FRAC_BITS = CBEB_FRAC_BITS
);
  logic                        valid;
  logic                        ready;
  logic [FRAC_BITS:0]          ctrl_x1;
  logic [FRAC_BITS:0]          ctrl_y1;
  logic [FRAC_BITS:0]          ctrl_x2;
  logic [FRAC_BITS:0]          ctrl_y2;
  logic signed [FRAC_BITS+1:0] position;

  modport source (
    output valid, ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2, position,
    input  ready
  );

  modport sink (
    input  valid, ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2, position,
    output ready
  );
endinterface

// Result channel: the eased value.
interface cbeb_out_if import cbeb_pkg::*; #(
  parameter int unsigned FRAC_BITS = CBEB_FRAC_BITS
);
  logic               valid;
  logic               ready;
  logic [FRAC_BITS:0] eased_value;

  modport source (
    output valid, eased_value,
    input  ready
  );

  modport sink (
    input  valid, eased_value,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/cubic_bezier_easing_bisection_top.sv
// ---------------------------------------------------------------------------
// Cubic Bezier easing by bisection: top level
// Solves x(t) = position by bisection on t and returns y(t) for a curve
// from (0,0) to (1,1) with two control points; the position is signed fixed point, all else unsigned.
// ---------------------------------------------------------------------------
//
//   Channel   Role    Handshake      Payload
//   in_item   sink    valid/ready    ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2, position
//   out_item  source  valid/ready    eased_value
//
// One transaction can enter in every clock cycle unless the pipeline holds.
// Each bisection step is four register stages: three multiplier levels
// of the curve evaluator and the compare-and-update.
// Reset is synchronous and active low; it clears only the valid and kind
// fields of the stage control and the output valid bit.
// When a result waits and the last stage holds another, the whole pipeline
// holds; otherwise it keeps moving and empty tail slots are squeezed out.
// ---------------------------------------------------------------------------
`default_nettype none

`include "cubic_bezier_easing_bisection_top_defines.svh"

module cubic_bezier_easing_bisection_top import cbeb_pkg::*; #(
  parameter int unsigned FRAC_BITS    = CBEB_FRAC_BITS,
  parameter int unsigned BISECT_STEPS = CBEB_BISECT_STEPS
) (
  input wire logic clk,
  input wire logic rst_n,
  cbeb_in_if.sink   in_item,
  cbeb_out_if.source out_item
);

  localparam int unsigned W       = FRAC_BITS + 1;
  localparam int unsigned SW      = FRAC_BITS + 4;
  localparam int unsigned BEZ_LAT = CBEB_BEZ_LATENCY;
  localparam logic [W-1:0] ONE    = {1'b1, {FRAC_BITS{1'b0}}};

  // Everything an item needs between bisection steps.
  typedef struct packed {
    logic [W-1:0]         lo;
    logic [W-1:0]         hi;
    logic [FRAC_BITS-1:0] pos;
    logic [W-1:0]         x1;
    logic [W-1:0]         x2;
    logic [W-1:0]         y1;
    logic [W-1:0]         y2;
  } rec_t;

  // Control values above one are limited to one.
  function automatic logic [W-1:0] sat_ctrl(input logic [W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  // Truncated midpoint of a bracket.
  function automatic logic [W-1:0] midpoint(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[W:1];
  endfunction

  logic       adv;
  pipe_ctl_t  ctl_r [BISECT_STEPS+1];
  rec_t       rec_r [BISECT_STEPS+1];

  // Entry: classify the position and set up the starting bracket.
  pipe_ctl_t ctl_nxt;
  rec_t      rec_nxt;
  kind_t     kind_in;
  logic      pos_sign;

  assign pos_sign = in_item.position[FRAC_BITS+1];

  always_comb begin
    if (pos_sign || (in_item.position == '0)) begin
      kind_in = KIND_ZERO;
    end else if (in_item.position[FRAC_BITS]) begin
      kind_in = KIND_ONE;
    end else begin
      kind_in = KIND_SOLVE;
    end
  end

  always_comb begin
    ctl_nxt.valid = in_item.valid;
    ctl_nxt.kind  = kind_in;
    rec_nxt.lo    = '0;
    rec_nxt.hi    = ONE;
    rec_nxt.pos   = in_item.position[FRAC_BITS-1:0];
    rec_nxt.x1    = sat_ctrl(in_item.ctrl_x1);
    rec_nxt.x2    = sat_ctrl(in_item.ctrl_x2);
    rec_nxt.y1    = sat_ctrl(in_item.ctrl_y1);
    rec_nxt.y2    = sat_ctrl(in_item.ctrl_y2);
  end

  assign in_item.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '{valid: 1'b0, kind: KIND_SOLVE};
    end else if (adv) begin
      ctl_r[0] <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rec_r[0] <= rec_nxt;
    end
  end

  // Bisection steps: evaluate x at the midpoint, then narrow the bracket.
  for (genvar k = 0; k < BISECT_STEPS; k++) begin : g_step
    logic [SW-1:0] x_sum;
    logic [W-1:0]  t_end;
    logic          below;
    rec_t          upd_nxt;
    pipe_ctl_t     dly_ctl_r [BEZ_LAT];
    rec_t          dly_rec_r [BEZ_LAT];

    cbeb_bez #(
      .FRAC_BITS (FRAC_BITS)
    ) u_bez (
      .clk   (clk),
      .en    (adv),
      .t_i   (midpoint(rec_r[k].lo, rec_r[k].hi)),
      .p_i   (rec_r[k].x1),
      .q_i   (rec_r[k].x2),
      .sum_o (x_sum)
    );

    // The bracket and control points keep pace with the evaluator.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        for (int i = 0; i < BEZ_LAT; i++) begin
          dly_ctl_r[i] <= '{valid: 1'b0, kind: KIND_SOLVE};
        end
      end else if (adv) begin
        dly_ctl_r[0] <= ctl_r[k];
        for (int i = 1; i < BEZ_LAT; i++) begin
          dly_ctl_r[i] <= dly_ctl_r[i-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dly_rec_r[0] <= rec_r[k];
        for (int i = 1; i < BEZ_LAT; i++) begin
          dly_rec_r[i] <= dly_rec_r[i-1];
        end
      end
    end

    // Raise lo while the curve is still short of the position, else lower hi.
    assign t_end = midpoint(dly_rec_r[BEZ_LAT-1].lo, dly_rec_r[BEZ_LAT-1].hi);
    assign below = x_sum < SW'(dly_rec_r[BEZ_LAT-1].pos);

    always_comb begin
      upd_nxt    = dly_rec_r[BEZ_LAT-1];
      upd_nxt.lo = below ? t_end : dly_rec_r[BEZ_LAT-1].lo;
      upd_nxt.hi = below ? dly_rec_r[BEZ_LAT-1].hi : t_end;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '{valid: 1'b0, kind: KIND_SOLVE};
      end else if (adv) begin
        ctl_r[k+1] <= dly_ctl_r[BEZ_LAT-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rec_r[k+1] <= upd_nxt;
      end
    end
  end

  // Final evaluation of y at the midpoint of the last bracket.
  logic [SW-1:0] y_sum;
  pipe_ctl_t     fin_ctl_r [BEZ_LAT];
  pipe_ctl_t     fin_ctl;
  logic          fin_valid;

  cbeb_bez #(
    .FRAC_BITS (FRAC_BITS)
  ) u_bez_y (
    .clk   (clk),
    .en    (adv),
    .t_i   (midpoint(rec_r[BISECT_STEPS].lo, rec_r[BISECT_STEPS].hi)),
    .p_i   (rec_r[BISECT_STEPS].y1),
    .q_i   (rec_r[BISECT_STEPS].y2),
    .sum_o (y_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BEZ_LAT; i++) begin
        fin_ctl_r[i] <= '{valid: 1'b0, kind: KIND_SOLVE};
      end
    end else if (adv) begin
      fin_ctl_r[0] <= ctl_r[BISECT_STEPS];
      for (int i = 1; i < BEZ_LAT; i++) begin
        fin_ctl_r[i] <= fin_ctl_r[i-1];
      end
    end
  end

  assign fin_ctl   = fin_ctl_r[BEZ_LAT-1];
  assign fin_valid = fin_ctl.valid;

  // Clamped positions bypass the curve; a solved value is limited to one.
  logic [W-1:0] result;

  always_comb begin
    case (fin_ctl.kind)
      KIND_ZERO:  result = '0;
      KIND_ONE:   result = ONE;
      KIND_SOLVE: result = (y_sum > SW'(ONE)) ? ONE : y_sum[W-1:0];
      default:    result = '0;
    endcase
  end

  // Output register. The pipeline moves unless a waiting result would be
  // overwritten by a valid one behind it.
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] out_value_r;

  assign adv = out_item.ready || !out_valid_r || !fin_valid;

  always_comb begin
    if (adv && fin_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_item.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fin_valid) begin
      out_value_r <= result;
    end
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.eased_value = out_value_r;

  // Checks on the stall logic, the entry stage, the result range and the zero clamp.
  `CBEB_ASSERT_SAME(a_stall_blocks_input, out_valid_r && !out_item.ready && fin_valid, !in_item.ready, "Input taken while the pipeline is blocked.")
  `CBEB_ASSERT_SAME(a_result_in_range, out_valid_r, out_value_r <= ONE, "Eased value above one.")
  `CBEB_ASSERT_NEXT(a_entry_captured, in_item.valid && in_item.ready, ctl_r[0].valid, "Accepted transaction missing from the first stage.")
  `CBEB_ASSERT_NEXT(a_clamp_zero, adv && fin_valid && fin_ctl.kind == KIND_ZERO, out_valid_r && out_value_r == '0, "Position at or below zero gave a non-zero result.")

endmodule

`default_nettype wire

>>> hdl/cbeb_bez.sv
// ---------------------------------------------------------------------------
// Cubic Bezier easing: curve evaluator
// Three-stage pipelined evaluation of one curve coordinate at parameter t.
// ---------------------------------------------------------------------------
`default_nettype none

module cbeb_bez import cbeb_pkg::*; #(
  parameter int unsigned FRAC_BITS = CBEB_FRAC_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [FRAC_BITS:0]   t_i,
  input  wire logic [FRAC_BITS:0]   p_i,
  input  wire logic [FRAC_BITS:0]   q_i,
  output logic      [FRAC_BITS+3:0] sum_o
);

  localparam int unsigned W  = FRAC_BITS + 1;
  localparam int unsigned SW = FRAC_BITS + 4;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Truncating fixed-point product. Both operands are at most one, so the
  // result fits in the operand width.
  function automatic logic [W-1:0] fx_mul(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [2*W-1:0] prod;
    prod = a * b;
    return prod[FRAC_BITS +: W];
  endfunction

  // Stage 1: squares of t and of its complement.
  logic [W-1:0] it;
  logic [W-1:0] s1_t_r, s1_it_r, s1_t2_r, s1_ii_r, s1_p_r, s1_q_r;

  assign it = ONE - t_i;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_t_r  <= t_i;
      s1_it_r <= it;
      s1_t2_r <= fx_mul(t_i, t_i);
      s1_ii_r <= fx_mul(it, it);
      s1_p_r  <= p_i;
      s1_q_r  <= q_i;
    end
  end

  // Stage 2: the three cubic basis terms.
  logic [W-1:0] s2_a_r, s2_b_r, s2_c_r, s2_p_r, s2_q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_a_r <= fx_mul(s1_ii_r, s1_t_r);
      s2_b_r <= fx_mul(s1_it_r, s1_t2_r);
      s2_c_r <= fx_mul(s1_t2_r, s1_t_r);
      s2_p_r <= s1_p_r;
      s2_q_r <= s1_q_r;
    end
  end

  // Stage 3: weight the inner terms by the control coordinates.
  logic [W-1:0] s3_ap_r, s3_bq_r, s3_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ap_r <= fx_mul(s2_a_r, s2_p_r);
      s3_bq_r <= fx_mul(s2_b_r, s2_q_r);
      s3_c_r  <= s2_c_r;
    end
  end

  // Weighted sum: three times each inner term plus the cubic term.
  logic [SW-1:0] ap3, bq3;

  assign ap3   = (SW'(s3_ap_r) << 1) + SW'(s3_ap_r);
  assign bq3   = (SW'(s3_bq_r) << 1) + SW'(s3_bq_r);
  assign sum_o = ap3 + bq3 + SW'(s3_c_r);

endmodule

`default_nettype wire
